// ===== hdl/rbps_pkg.sv =====
// rbps_pkg: types and constants shared by the route selection engine
// no dependencies
package rbps_pkg;

   localparam int NodeCountDefault = 256;
   localparam int CandSlotsDefault = 8;
   localparam logic [7:0] CostMax = 8'd255;

   localparam logic [1:0] RelNone     = 2'd0;
   localparam logic [1:0] RelCustomer = 2'd1;
   localparam logic [1:0] RelPeer     = 2'd2;
   localparam logic [1:0] RelProvider = 2'd3;

   typedef struct packed {
      logic [7:0] sender_id;
      logic [7:0] dest_id;
      logic [7:0] advertised_cost;
      logic [1:0] relation;
   } req_type;

   typedef struct packed {
      logic       announce;
      logic [7:0] out_dest_id;
      logic [7:0] next_hop;
      logic [7:0] route_cost;
      logic [1:0] route_relation;
      logic       list_full;
   } rsp_type;

   typedef struct packed {
      logic [7:0] nbr;
      logic [7:0] cost;
      logic [1:0] rel;
   } cand_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      sat_inc = (v == CostMax) ? CostMax : v + 8'd1;
   endfunction

endpackage

// ===== hdl/route_best_path_select.sv =====
// route_best_path_select: per-destination candidate list and route choice
// depends on rbps_pkg
//
// channel  | direction | payload
// req_     | in        | rbps_pkg::req_type advertisement
// rsp_     | out       | rbps_pkg::rsp_type route report
// csr_     | in        | own node id, 8 bits
//
// one item at a time: the list of the destination is loaded into local registers,
// then find, place and shift or sort, select and write back run one slot a cycle
// a new destination goes from load straight to write back; for a known one the time
// grows with the list length
// after reset a clearing pass runs over every entry of the known/count
// store, during which req_ready stays low
// a stalled rsp_ holds the finished item in its report state until the register frees
module route_best_path_select #(
   parameter int NODE_COUNT      = rbps_pkg::NodeCountDefault,
   parameter int CANDIDATE_SLOTS = rbps_pkg::CandSlotsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rbps_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rbps_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_data
);
   import rbps_pkg::*;

   localparam int DW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int SW = (CANDIDATE_SLOTS > 1) ? $clog2(CANDIDATE_SLOTS) : 1;
   localparam int CW = $clog2(CANDIDATE_SLOTS + 1);
   // reciprocal used to fold an id onto a table smaller than the id space
   localparam int RecipMul = (65536 + NODE_COUNT - 1) / NODE_COUNT;

   // memories: per destination known flag, count and route, per slot candidate
   logic          known_mem [NODE_COUNT];
   logic [CW-1:0] cnt_mem   [NODE_COUNT];
   cand_type      route_mem [NODE_COUNT];
   cand_type      cand_mem  [NODE_COUNT][CANDIDATE_SLOTS];

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LOAD, S_FIND, S_PLACE, S_SHIFT, S_SORT,
      S_SELECT, S_STORE, S_REPORT
   } state_type;

   state_type     state_ff;
   logic [DW-1:0] clr_ff;
   logic [7:0]    own_ff;
   req_type       req_ff;
   logic [7:0]    cost_ff;
   logic [DW-1:0] slot_ff;
   logic          known_ff;
   logic [CW-1:0] cnt_ff;
   cand_type      route_ff;
   logic [CW-1:0] i_ff;      // scan index
   logic [CW-1:0] j_ff;      // sort position
   logic [CW-1:0] pos_ff;    // insert position
   logic          full_ff;
   logic          announce_ff;
   cand_type      pick_c_ff; // best candidate so far, rel none when empty
   cand_type      list_ff [CANDIDATE_SLOTS];
   rsp_type       rsp_ff;
   logic          rspv_ff;

   // id to table slot, a plain truncation when the table covers all ids
   function automatic logic [DW-1:0] slot_of(input logic [7:0] d);
      logic [23:0] prod;
      logic [15:0] rem;
      prod = 24'(d) * 24'(RecipMul);
      rem  = 16'(d) - 16'(prod[23:16]) * 16'(NODE_COUNT);
      if (NODE_COUNT >= 256) slot_of = DW'(d);
      else slot_of = rem[DW-1:0];
   endfunction

   logic [DW-1:0] req_slot;
   logic [CW-1:0] i_dec, j_dec;
   logic [SW-1:0] i_s, i_prev, j_s, j_prev;
   cand_type      new_cand;

   assign req_slot = slot_of(req_data.dest_id);
   assign i_dec    = i_ff - CW'(1);
   assign j_dec    = j_ff - CW'(1);
   assign i_s      = i_ff[SW-1:0];
   assign i_prev   = i_dec[SW-1:0];
   assign j_s      = j_ff[SW-1:0];
   assign j_prev   = j_dec[SW-1:0];
   assign new_cand = '{nbr: req_ff.sender_id, cost: cost_ff, rel: req_ff.relation};

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         own_ff   <= '0;
         rspv_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) own_ff <= csr_data;
         if (state_ff == S_REPORT && (!rspv_ff || rsp_ready)) rspv_ff <= 1'b1;
         else if (rsp_ready) rspv_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               known_mem[clr_ff] <= 1'b0;
               cnt_mem[clr_ff]   <= '0;
               clr_ff <= clr_ff + DW'(1);
               if (clr_ff == DW'(NODE_COUNT - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff      <= req_data;
                  cost_ff     <= sat_inc(req_data.advertised_cost);
                  slot_ff     <= req_slot;
                  known_ff    <= known_mem[req_slot];
                  cnt_ff      <= cnt_mem[req_slot];
                  route_ff    <= route_mem[req_slot];
                  full_ff     <= 1'b0;
                  announce_ff <= 1'b0;
                  pick_c_ff   <= '{nbr: '0, cost: '0, rel: RelNone};
                  i_ff        <= '0;
                  state_ff    <= S_LOAD;
               end
            end
            S_LOAD: begin
               if (!known_ff) begin
                  // first advertisement: learned as the route and announced
                  list_ff[0]  <= new_cand;
                  route_ff    <= new_cand;
                  cnt_ff      <= CW'(1);
                  announce_ff <= 1'b1;
                  i_ff        <= '0;
                  state_ff    <= S_STORE;
               end else if (i_ff >= cnt_ff) begin
                  i_ff     <= '0;
                  state_ff <= S_FIND;
               end else begin
                  list_ff[i_s] <= cand_mem[slot_ff][i_s];
                  i_ff <= i_ff + CW'(1);
               end
            end
            S_FIND: begin
               if (i_ff >= cnt_ff) begin
                  if (cnt_ff < CW'(CANDIDATE_SLOTS)) begin
                     i_ff     <= '0;
                     state_ff <= S_PLACE;
                  end else begin
                     // no room: drop the sender, select on the old list
                     full_ff  <= 1'b1;
                     i_ff     <= '0;
                     state_ff <= S_SELECT;
                  end
               end else if (list_ff[i_s].nbr == req_ff.sender_id) begin
                  list_ff[i_s].cost <= cost_ff;
                  i_ff     <= CW'(1);
                  j_ff     <= CW'(1);
                  state_ff <= S_SORT;
               end else begin
                  i_ff <= i_ff + CW'(1);
               end
            end
            S_PLACE: begin
               // new entry goes after every entry of lower or equal cost
               if (i_ff < cnt_ff && list_ff[i_s].cost <= cost_ff) begin
                  i_ff <= i_ff + CW'(1);
               end else begin
                  pos_ff   <= i_ff;
                  i_ff     <= cnt_ff;
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               if (i_ff == pos_ff) begin
                  list_ff[i_s] <= new_cand;
                  cnt_ff   <= cnt_ff + CW'(1);
                  i_ff     <= '0;
                  state_ff <= S_SELECT;
               end else begin
                  list_ff[i_s] <= list_ff[i_prev];
                  i_ff <= i_dec;
               end
            end
            S_SORT: begin
               // stable insertion sort by cost, one compare a cycle
               if (i_ff >= cnt_ff) begin
                  i_ff     <= '0;
                  state_ff <= S_SELECT;
               end else if (j_ff != '0 && list_ff[j_prev].cost > list_ff[j_s].cost) begin
                  list_ff[j_prev] <= list_ff[j_s];
                  list_ff[j_s]    <= list_ff[j_prev];
                  j_ff <= j_dec;
               end else begin
                  i_ff <= i_ff + CW'(1);
                  j_ff <= i_ff + CW'(1);
               end
            end
            S_SELECT: begin
               // keeps the first entry of the best class seen, customer or own node as destination ends the scan
               if (own_ff == req_ff.dest_id || i_ff >= cnt_ff ||
                   pick_c_ff.rel == RelCustomer) begin
                  i_ff     <= '0;
                  state_ff <= S_STORE;
               end else begin
                  if (list_ff[i_s].rel != RelNone &&
                      (pick_c_ff.rel == RelNone || list_ff[i_s].rel < pick_c_ff.rel)) begin
                     pick_c_ff <= list_ff[i_s];
                  end
                  i_ff <= i_ff + CW'(1);
               end
            end
            S_STORE: begin
               if (i_ff < cnt_ff) begin
                  cand_mem[slot_ff][i_s] <= list_ff[i_s];
                  i_ff <= i_ff + CW'(1);
               end else begin
                  known_mem[slot_ff] <= 1'b1;
                  cnt_mem[slot_ff]   <= cnt_ff;
                  if (pick_c_ff.rel != RelNone) begin
                     route_mem[slot_ff] <= pick_c_ff;
                     route_ff           <= pick_c_ff;
                     announce_ff        <= (pick_c_ff.nbr != route_ff.nbr);
                  end else begin
                     route_mem[slot_ff] <= route_ff;
                  end
                  state_ff <= S_REPORT;
               end
            end
            S_REPORT: begin
               if (!rspv_ff || rsp_ready) begin
                  rsp_ff <= '{announce: announce_ff, out_dest_id: req_ff.dest_id,
                              next_hop: route_ff.nbr, route_cost: route_ff.cost,
                              route_relation: route_ff.rel, list_full: full_ff};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
